/* hdl/ffa_pkg.sv */
// Shared constants, codes and types for the fall and fever alert block.
package ffa_pkg;

    localparam int OP_W     = 2;
    localparam int BYTE_W   = 8;
    localparam int AXIS_W   = 14;
    localparam int ADC_W    = 10;
    localparam int SUM_W    = 18;
    localparam int WIN_W    = 8;
    localparam int REPLY_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 18;

    // operation codes
    localparam logic [OP_W-1:0] OP_ACCEL = 2'd0;
    localparam logic [OP_W-1:0] OP_TEMP  = 2'd1;
    localparam logic [OP_W-1:0] OP_HOST  = 2'd2;

    // host request characters
    localparam logic [BYTE_W-1:0] REQ_FALL  = 8'h52; // 'R'
    localparam logic [BYTE_W-1:0] REQ_FEVER = 8'h4B; // 'K'
    localparam logic [BYTE_W-1:0] REQ_TEMP  = 8'h46; // 'F'

    // reply codes
    localparam logic [REPLY_W-1:0] REPLY_CLEAR = 2'd0;
    localparam logic [REPLY_W-1:0] REPLY_SET   = 2'd1;
    localparam logic [REPLY_W-1:0] REPLY_TEMP  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_JERK_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FEVER_THR = 2'd2;

    // register reset values
    localparam logic [AXIS_W-1:0] JERK_THR_RST  = 14'd1500;
    localparam logic [WIN_W-1:0]  WIN_LEN_RST   = 8'd200;
    localparam logic [SUM_W-1:0]  FEVER_THR_RST = 18'd37442;

    // status from the temperature accumulator
    typedef struct packed {
        logic             fever_hit;
        logic [SUM_W-1:0] last_sum;
    } ffa_temp_stat_t;

    // one result transaction
    typedef struct packed {
        logic [REPLY_W-1:0] reply_code;
        logic [SUM_W-1:0]   temperature_sum;
    } ffa_result_t;

endpackage

/* hdl/ffa_axis_lane.sv */
// One accelerometer axis lane: forms the 14-bit value and checks the jerk.
module ffa_axis_lane (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        sample_en,
    input  logic [ffa_pkg::BYTE_W-1:0]  data_high,
    input  logic [ffa_pkg::BYTE_W-1:0]  data_low,
    input  logic [ffa_pkg::AXIS_W-1:0]  jerk_threshold,
    output logic                        jerk
);
    import ffa_pkg::*;

    logic [AXIS_W-1:0] prev_reg;
    logic [AXIS_W-1:0] raw;
    logic [AXIS_W:0]   diff;
    logic [AXIS_W:0]   mag;

    assign raw  = {data_high, data_low[BYTE_W-1:2]};
    assign diff = $signed({raw[AXIS_W-1], raw}) - $signed({prev_reg[AXIS_W-1], prev_reg});
    assign mag  = diff[AXIS_W] ? (~diff + 1'b1) : diff;
    assign jerk = mag > {1'b0, jerk_threshold};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
        end else if (sample_en) begin
            prev_reg <= raw;
        end
    end

endmodule

/* hdl/ffa_temp_acc.sv */
// Temperature window accumulator: sums ADC samples, reports completed windows.
module ffa_temp_acc (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        sample_en,
    input  logic [ffa_pkg::ADC_W-1:0]   adc_sample,
    input  logic [ffa_pkg::WIN_W-1:0]   window_length,
    input  logic [ffa_pkg::SUM_W-1:0]   fever_sum_threshold,
    output ffa_pkg::ffa_temp_stat_t     stat
);
    import ffa_pkg::*;

    logic [SUM_W-1:0] running_reg;
    logic [WIN_W-1:0] taken_reg;
    logic [SUM_W-1:0] last_reg;
    logic [SUM_W-1:0] sum;
    logic [WIN_W:0]   count;
    logic             done;

    assign sum   = running_reg + {{(SUM_W-ADC_W){1'b0}}, adc_sample};
    assign count = {1'b0, taken_reg} + 1'b1;
    // a shortened window completes on the next sample
    assign done  = count >= {1'b0, window_length};

    assign stat.fever_hit = sample_en && done && (sum >= fever_sum_threshold);
    assign stat.last_sum  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= '0;
            taken_reg   <= '0;
            last_reg    <= '0;
        end else if (sample_en) begin
            if (done) begin
                last_reg    <= sum;
                running_reg <= '0;
                taken_reg   <= '0;
            end else begin
                running_reg <= sum;
                taken_reg   <= count[WIN_W-1:0];
            end
        end
    end

endmodule

/* hdl/fall_and_fever_alert_top.sv */
// Top level of the fall and fever alert block.
//
// Takes one input transaction per clock while s_ready is high: an accelerometer
// sample (operation 0), a temperature ADC sample (operation 1) or a host
// request byte (operation 2). The three axes are checked side by side in three
// identical lanes, each holding its axis's previous value; their jerk results
// are ORed into the sticky fall flag in the same cycle. Temperature samples are
// summed over a window of window_length samples; the sum of every completed
// window is kept, and one at or above fever_sum_threshold sets the sticky
// fever flag. Host 'R' and 'K' reply with the fall or fever flag and clear it,
// 'F' replies with the kept window sum; other bytes and operation 3 give
// nothing. The state seen by a request is that left by all earlier
// transactions. Results leave through an output register backed by one skid
// entry, so input keeps flowing while a reply waits; s_ready only drops when
// both hold a reply. Configuration writes take effect on the next cycle and
// should only be made while the block is idle.
module fall_and_fever_alert_top (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_we,
    input  logic [ffa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ffa_pkg::CFG_W-1:0]      cfg_data,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ffa_pkg::OP_W-1:0]       s_operation,
    input  logic [ffa_pkg::BYTE_W-1:0]     s_x_high,
    input  logic [ffa_pkg::BYTE_W-1:0]     s_x_low,
    input  logic [ffa_pkg::BYTE_W-1:0]     s_y_high,
    input  logic [ffa_pkg::BYTE_W-1:0]     s_y_low,
    input  logic [ffa_pkg::BYTE_W-1:0]     s_z_high,
    input  logic [ffa_pkg::BYTE_W-1:0]     s_z_low,
    input  logic [ffa_pkg::ADC_W-1:0]      s_adc_sample,
    input  logic [ffa_pkg::BYTE_W-1:0]     s_request_byte,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ffa_pkg::REPLY_W-1:0]    m_reply_code,
    output logic [ffa_pkg::SUM_W-1:0]      m_temperature_sum
);
    import ffa_pkg::*;

    // configuration registers
    logic [AXIS_W-1:0] jerk_thr_reg;
    logic [WIN_W-1:0]  win_len_reg;
    logic [SUM_W-1:0]  fever_thr_reg;

    // sticky flags
    logic fall_flag_reg,  fall_flag_next;
    logic fever_flag_reg, fever_flag_next;

    // output register and skid entry
    logic        m_valid_reg,  m_valid_next;
    ffa_result_t m_data_reg,   m_data_next;
    logic        skid_valid_reg, skid_valid_next;
    ffa_result_t skid_data_reg,  skid_data_next;

    logic           accept;
    logic           accel_en;
    logic           temp_en;
    logic           host_en;
    logic           req_fall;
    logic           req_fever;
    logic           req_temp;
    logic           produce;
    logic           pop;
    logic [2:0]     lane_jerk;
    logic           any_jerk;
    ffa_temp_stat_t temp_stat;
    ffa_result_t    result;

    assign s_ready  = !skid_valid_reg;
    assign accept   = s_valid && s_ready;
    assign accel_en = accept && (s_operation == OP_ACCEL);
    assign temp_en  = accept && (s_operation == OP_TEMP);
    assign host_en  = accept && (s_operation == OP_HOST);

    assign req_fall  = host_en && (s_request_byte == REQ_FALL);
    assign req_fever = host_en && (s_request_byte == REQ_FEVER);
    assign req_temp  = host_en && (s_request_byte == REQ_TEMP);
    assign produce   = req_fall || req_fever || req_temp;

    // configuration write port; index 3 is ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            jerk_thr_reg  <= JERK_THR_RST;
            win_len_reg   <= WIN_LEN_RST;
            fever_thr_reg <= FEVER_THR_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_JERK_THR:  jerk_thr_reg  <= cfg_data[AXIS_W-1:0];
                CFG_WIN_LEN:   win_len_reg   <= cfg_data[WIN_W-1:0];
                CFG_FEVER_THR: fever_thr_reg <= cfg_data[SUM_W-1:0];
                default: ;
            endcase
        end
    end

    // three axis lanes in parallel
    ffa_axis_lane u_lane_x (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .sample_en      (accel_en),
        .data_high      (s_x_high),
        .data_low       (s_x_low),
        .jerk_threshold (jerk_thr_reg),
        .jerk           (lane_jerk[0])
    );

    ffa_axis_lane u_lane_y (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .sample_en      (accel_en),
        .data_high      (s_y_high),
        .data_low       (s_y_low),
        .jerk_threshold (jerk_thr_reg),
        .jerk           (lane_jerk[1])
    );

    ffa_axis_lane u_lane_z (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .sample_en      (accel_en),
        .data_high      (s_z_high),
        .data_low       (s_z_low),
        .jerk_threshold (jerk_thr_reg),
        .jerk           (lane_jerk[2])
    );

    // merge: any axis over threshold
    assign any_jerk = |lane_jerk;

    ffa_temp_acc u_temp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .sample_en           (temp_en),
        .adc_sample          (s_adc_sample),
        .window_length       (win_len_reg),
        .fever_sum_threshold (fever_thr_reg),
        .stat                (temp_stat)
    );

    // reply built from the flags as they stand before this transaction
    always_comb begin
        result.reply_code      = REPLY_CLEAR;
        result.temperature_sum = '0;
        if (req_fall) begin
            result.reply_code = fall_flag_reg ? REPLY_SET : REPLY_CLEAR;
        end else if (req_fever) begin
            result.reply_code = fever_flag_reg ? REPLY_SET : REPLY_CLEAR;
        end else if (req_temp) begin
            result.reply_code      = REPLY_TEMP;
            result.temperature_sum = temp_stat.last_sum;
        end
    end

    always_comb begin
        fall_flag_next  = (fall_flag_reg && !req_fall) || (accel_en && any_jerk);
        fever_flag_next = (fever_flag_reg && !req_fever) || temp_stat.fever_hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fall_flag_reg  <= 1'b0;
            fever_flag_reg <= 1'b0;
        end else begin
            fall_flag_reg  <= fall_flag_next;
            fever_flag_reg <= fever_flag_next;
        end
    end

    // output register with skid entry
    assign pop = m_valid_reg && m_ready;

    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                m_data_next     = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (produce) begin
            if (!m_valid_reg || pop) begin
                m_valid_next = 1'b1;
                m_data_next  = result;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = result;
            end
        end else if (pop) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_reply_code      = m_data_reg.reply_code;
    assign m_temperature_sum = m_data_reg.temperature_sum;

    // checks
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry holds a reply while the output register is empty");

    a_fall_query_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        req_fall |=> !fall_flag_reg)
        else $error("fall flag still set after an R query");

    a_fever_query_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (req_fever && !temp_stat.fever_hit) |=> !fever_flag_reg)
        else $error("fever flag still set after a K query");

    a_reply_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        produce |=> m_valid_reg)
        else $error("reply transaction lost");

endmodule

/* tb/sv/ffa_alert_checker.sv */
// Reply predictor and scoreboard for the fall and fever alert block.
module ffa_alert_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [ffa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ffa_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [ffa_pkg::OP_W-1:0]       s_operation,
    input  logic [ffa_pkg::BYTE_W-1:0]     s_x_high,
    input  logic [ffa_pkg::BYTE_W-1:0]     s_x_low,
    input  logic [ffa_pkg::BYTE_W-1:0]     s_y_high,
    input  logic [ffa_pkg::BYTE_W-1:0]     s_y_low,
    input  logic [ffa_pkg::BYTE_W-1:0]     s_z_high,
    input  logic [ffa_pkg::BYTE_W-1:0]     s_z_low,
    input  logic [ffa_pkg::ADC_W-1:0]      s_adc_sample,
    input  logic [ffa_pkg::BYTE_W-1:0]     s_request_byte,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [ffa_pkg::REPLY_W-1:0]    m_reply_code,
    input  logic [ffa_pkg::SUM_W-1:0]      m_temperature_sum,
    output int                             mismatch_count,
    output int                             replies_pending
);
    import ffa_pkg::*;

    // register copies
    logic [AXIS_W-1:0] jerk_limit;
    logic [WIN_W-1:0]  window_len;
    logic [SUM_W-1:0]  fever_limit;

    // predicted block state
    logic [AXIS_W-1:0] last_x, last_y, last_z;
    logic              fall_seen, fever_seen;
    logic [SUM_W-1:0]  window_acc, kept_sum;
    logic [WIN_W-1:0]  window_fill;

    ffa_result_t expected_replies [$];
    ffa_result_t wanted;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: alert mismatch: %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // magnitude of the step between two signed 14-bit samples against the limit
    function automatic logic axis_jumped(input logic [AXIS_W-1:0] now_w,
                                         input logic [AXIS_W-1:0] prev_w,
                                         input logic [AXIS_W-1:0] limit);
        int diff;
        diff = int'($signed(now_w)) - int'($signed(prev_w));
        if (diff < 0)
            diff = -diff;
        return diff > int'(limit);
    endfunction

    task automatic predict_alert(input logic [OP_W-1:0]   op,
                                 input logic [BYTE_W-1:0] xh, xl, yh, yl, zh, zl,
                                 input logic [ADC_W-1:0]  adc,
                                 input logic [BYTE_W-1:0] req);
        logic [AXIS_W-1:0] nx, ny, nz;
        logic [SUM_W-1:0]  new_sum;
        logic [WIN_W:0]    new_fill;
        ffa_result_t       reply;
        nx = {xh, xl[7:2]};
        ny = {yh, yl[7:2]};
        nz = {zh, zl[7:2]};
        reply.reply_code      = REPLY_CLEAR;
        reply.temperature_sum = '0;
        case (op)
            OP_ACCEL: begin
                if (axis_jumped(nx, last_x, jerk_limit) || axis_jumped(ny, last_y, jerk_limit)
                        || axis_jumped(nz, last_z, jerk_limit))
                    fall_seen = 1'b1;
                last_x = nx;
                last_y = ny;
                last_z = nz;
            end
            OP_TEMP: begin
                new_sum  = window_acc + {{(SUM_W-ADC_W){1'b0}}, adc};
                new_fill = {1'b0, window_fill} + 1'b1;
                // a zero length behaves as one; a lowered length closes at once
                if (new_fill >= {1'b0, window_len}) begin
                    kept_sum = new_sum;
                    if (new_sum >= fever_limit)
                        fever_seen = 1'b1;
                    window_acc  = '0;
                    window_fill = '0;
                end else begin
                    window_acc  = new_sum;
                    window_fill = new_fill[WIN_W-1:0];
                end
            end
            OP_HOST: begin
                case (req)
                    REQ_FALL: begin
                        reply.reply_code = fall_seen ? REPLY_SET : REPLY_CLEAR;
                        fall_seen = 1'b0;
                        expected_replies.push_back(reply);
                    end
                    REQ_FEVER: begin
                        reply.reply_code = fever_seen ? REPLY_SET : REPLY_CLEAR;
                        fever_seen = 1'b0;
                        expected_replies.push_back(reply);
                    end
                    REQ_TEMP: begin
                        reply.reply_code      = REPLY_TEMP;
                        reply.temperature_sum = kept_sum;
                        expected_replies.push_back(reply);
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            jerk_limit  = JERK_THR_RST;
            window_len  = WIN_LEN_RST;
            fever_limit = FEVER_THR_RST;
            last_x      = '0;
            last_y      = '0;
            last_z      = '0;
            fall_seen   = 1'b0;
            fever_seen  = 1'b0;
            window_acc  = '0;
            kept_sum    = '0;
            window_fill = '0;
            expected_replies.delete();
            mismatch_count = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_JERK_THR:  jerk_limit  = cfg_data[AXIS_W-1:0];
                    CFG_WIN_LEN:   window_len  = cfg_data[WIN_W-1:0];
                    CFG_FEVER_THR: fever_limit = cfg_data[SUM_W-1:0];
                    default: ;
                endcase
            end
            // compare before predicting: a reply never leaves in its own cycle
            if (m_valid && m_ready) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch("reply with none outstanding", int'(m_reply_code), 0);
                end else begin
                    wanted = expected_replies.pop_front();
                    if (m_reply_code !== wanted.reply_code)
                        report_mismatch("reply_code", int'(m_reply_code),
                                        int'(wanted.reply_code));
                    if (m_temperature_sum !== wanted.temperature_sum)
                        report_mismatch("temperature_sum", int'(m_temperature_sum),
                                        int'(wanted.temperature_sum));
                end
            end
            if (s_valid && s_ready)
                predict_alert(s_operation, s_x_high, s_x_low, s_y_high, s_y_low,
                              s_z_high, s_z_low, s_adc_sample, s_request_byte);
        end
        replies_pending = expected_replies.size();
    end

endmodule

/* tb/sv/tb.sv */
// Testbench top for the fall and fever alert block: stimulus, idling and verdict.
module tb;
    import ffa_pkg::*;

    // operation code the block must ignore
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // longest run of cycles with no transaction on either channel
    localparam int WATCHDOG_LIMIT = 2000;
    // length of the deliberate receiver hold-off
    localparam int HOLD_CYCLES    = 120;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [BYTE_W-1:0] x_high;
        logic [BYTE_W-1:0] x_low;
        logic [BYTE_W-1:0] y_high;
        logic [BYTE_W-1:0] y_low;
        logic [BYTE_W-1:0] z_high;
        logic [BYTE_W-1:0] z_low;
        logic [ADC_W-1:0]  adc_sample;
        logic [BYTE_W-1:0] request_byte;
    } sensor_item_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [OP_W-1:0]      s_operation;
    logic [BYTE_W-1:0]    s_x_high, s_x_low, s_y_high, s_y_low, s_z_high, s_z_low;
    logic [ADC_W-1:0]     s_adc_sample;
    logic [BYTE_W-1:0]    s_request_byte;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [REPLY_W-1:0]   m_reply_code;
    logic [SUM_W-1:0]     m_temperature_sum;

    int mismatch_count;
    int replies_pending;

    // stimulus shaping
    int                tx_idle_pct  = 0;
    int                rx_stall_pct = 0;
    logic              hold_start   = 1'b0;
    int                hold_left;
    int                quiet_cycles;
    logic [AXIS_W-1:0] jerk_now     = JERK_THR_RST;
    logic [AXIS_W-1:0] axis_last [3];

    always #1 aclk = ~aclk;

    fall_and_fever_alert_top i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_x_high          (s_x_high),
        .s_x_low           (s_x_low),
        .s_y_high          (s_y_high),
        .s_y_low           (s_y_low),
        .s_z_high          (s_z_high),
        .s_z_low           (s_z_low),
        .s_adc_sample      (s_adc_sample),
        .s_request_byte    (s_request_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_reply_code      (m_reply_code),
        .m_temperature_sum (m_temperature_sum)
    );

    ffa_alert_checker i_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_x_high          (s_x_high),
        .s_x_low           (s_x_low),
        .s_y_high          (s_y_high),
        .s_y_low           (s_y_low),
        .s_z_high          (s_z_high),
        .s_z_low           (s_z_low),
        .s_adc_sample      (s_adc_sample),
        .s_request_byte    (s_request_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_reply_code      (m_reply_code),
        .m_temperature_sum (m_temperature_sum),
        .mismatch_count    (mismatch_count),
        .replies_pending   (replies_pending)
    );

    // Result side. A hold-off request forces m_ready low until hold_left counts
    // down to zero, so the output register and skid entry both fill and s_ready
    // drops; otherwise m_ready stalls at random with the phase's percentage.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_start) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog: any transaction on either channel restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one transaction and return at the edge where it is taken. The
    // caller must drive the next payload or drop valid in that same step.
    // The idle gap is drawn per cycle from tx_idle_pct.
    task automatic send_item(input sensor_item_t item);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_operation    <= item.operation;
        s_x_high       <= item.x_high;
        s_x_low        <= item.x_low;
        s_y_high       <= item.y_high;
        s_y_low        <= item.y_low;
        s_z_high       <= item.z_high;
        s_z_low        <= item.z_low;
        s_adc_sample   <= item.adc_sample;
        s_request_byte <= item.request_byte;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_accel(input logic [BYTE_W-1:0] xh, xl, yh, yl, zh, zl);
        sensor_item_t item;
        item = '0;
        item.operation = OP_ACCEL;
        item.x_high = xh;
        item.x_low  = xl;
        item.y_high = yh;
        item.y_low  = yl;
        item.z_high = zh;
        item.z_low  = zl;
        send_item(item);
    endtask

    task automatic send_temp(input logic [ADC_W-1:0] adc);
        sensor_item_t item;
        item = '0;
        item.operation  = OP_TEMP;
        item.adc_sample = adc;
        send_item(item);
    endtask

    task automatic send_host(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] req);
        sensor_item_t item;
        item = '0;
        item.operation    = op;
        item.request_byte = req;
        send_item(item);
    endtask

    // Stop offering and wait until every reply has been taken, then go on
    // waiting so an accepted sample with no reply has finished too.
    task automatic settle_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (replies_pending != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // All three registers, one write per cycle. Bits above each register's
    // width carry junk, which the block must drop.
    task automatic set_config(input logic [AXIS_W-1:0] jerk, input logic [WIN_W-1:0] win,
                              input logic [SUM_W-1:0] fever);
        logic [CFG_W-1:0] word;
        word = CFG_W'($urandom);
        word[AXIS_W-1:0] = jerk;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_JERK_THR;
        cfg_data  <= word;
        @(posedge aclk);
        word = CFG_W'($urandom);
        word[WIN_W-1:0] = win;
        cfg_index <= CFG_WIN_LEN;
        cfg_data  <= word;
        @(posedge aclk);
        cfg_index <= CFG_FEVER_THR;
        cfg_data  <= fever;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        jerk_now = jerk;
    endtask

    // Random transaction. Axis values mostly move from the last sent value by
    // a step near the jerk threshold so both sides of the compare are hit;
    // some are drawn anew. Fields the operation does not use carry noise.
    function automatic sensor_item_t random_item();
        sensor_item_t      item;
        logic [AXIS_W-1:0] w;
        logic [BYTE_W-1:0] hb [3];
        logic [BYTE_W-1:0] lb [3];
        int                pick;
        int                span;
        int                v;
        pick = $urandom_range(99);
        span = int'(jerk_now);
        item.operation    = OP_UNUSED;
        item.x_high       = BYTE_W'($urandom_range(255));
        item.x_low        = BYTE_W'($urandom_range(255));
        item.y_high       = BYTE_W'($urandom_range(255));
        item.y_low        = BYTE_W'($urandom_range(255));
        item.z_high       = BYTE_W'($urandom_range(255));
        item.z_low        = BYTE_W'($urandom_range(255));
        item.adc_sample   = ADC_W'($urandom_range(1023));
        item.request_byte = BYTE_W'($urandom_range(255));
        if (pick < 38) begin
            item.operation = OP_ACCEL;
            for (int k = 0; k < 3; k++) begin
                if ($urandom_range(9) < 2) begin
                    w = AXIS_W'($urandom_range(16383));
                end else begin
                    v = int'(axis_last[k]) + int'($urandom_range(2 * span + 4)) - (span + 2);
                    w = v[AXIS_W-1:0];
                end
                axis_last[k] = w;
                hb[k] = w[AXIS_W-1:6];
                lb[k] = BYTE_W'($urandom_range(255));
                lb[k][7:2] = w[5:0];
            end
            item.x_high = hb[0];
            item.x_low  = lb[0];
            item.y_high = hb[1];
            item.y_low  = lb[1];
            item.z_high = hb[2];
            item.z_low  = lb[2];
        end else if (pick < 72) begin
            item.operation = OP_TEMP;
            case ($urandom_range(9))
                0: item.adc_sample = '0;
                1: item.adc_sample = '1;
                default: ;
            endcase
        end else if (pick < 95) begin
            item.operation = OP_HOST;
            case ($urandom_range(9))
                0, 1, 2: item.request_byte = REQ_FALL;
                3, 4, 5: item.request_byte = REQ_FEVER;
                6, 7, 8: item.request_byte = REQ_TEMP;
                default: ;
            endcase
        end
        return item;
    endfunction

    // One phase: drain, reconfigure, optionally hold the receiver off while
    // a burst of 'F' requests piles up, then random traffic. Ignored
    // transactions (unused operation, unknown host byte) are not counted.
    task automatic run_phase(input logic [AXIS_W-1:0] jerk, input logic [WIN_W-1:0] win,
                             input logic [SUM_W-1:0] fever, input int tx_pct,
                             input int rx_pct, input int items, input bit hold_first);
        sensor_item_t item;
        int           done;
        settle_idle();
        set_config(jerk, win, fever);
        rx_stall_pct <= rx_pct;
        if (hold_first) begin
            tx_idle_pct = 0;
            hold_start <= 1'b1;
            @(posedge aclk);
            hold_start <= 1'b0;
            repeat (12) send_host(OP_HOST, REQ_TEMP);
        end
        tx_idle_pct = tx_pct;
        done = 0;
        while (done < items) begin
            item = random_item();
            send_item(item);
            if (item.operation == OP_ACCEL || item.operation == OP_TEMP
                    || (item.operation == OP_HOST && (item.request_byte == REQ_FALL
                        || item.request_byte == REQ_FEVER || item.request_byte == REQ_TEMP)))
                done++;
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_JERK_THR;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_operation    = OP_ACCEL;
        s_x_high       = '0;
        s_x_low        = '0;
        s_y_high       = '0;
        s_y_low        = '0;
        s_z_high       = '0;
        s_z_low        = '0;
        s_adc_sample   = '0;
        s_request_byte = '0;
        for (int k = 0; k < 3; k++)
            axis_last[k] = '0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, reset register values: queries with nothing flagged yet.
        send_host(OP_HOST, REQ_FALL);
        send_host(OP_HOST, REQ_FEVER);
        send_host(OP_HOST, REQ_TEMP);
        // first sample is measured against zero: x at full positive scale
        send_accel(8'h7F, 8'hFC, 8'h00, 8'h00, 8'h00, 8'h00);
        send_host(OP_HOST, REQ_FALL);
        send_host(OP_HOST, REQ_FALL);
        // full negative scale on x, swing across the whole range
        send_accel(8'h80, 8'h00, 8'h80, 8'h03, 8'h7F, 8'hFF);
        send_accel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_host(OP_HOST, REQ_FALL);
        // step of exactly the threshold (-1 to 1499) must not trip
        send_accel(8'h17, 8'h6C, 8'h17, 8'h6C, 8'h17, 8'h6C);
        send_host(OP_HOST, REQ_FALL);
        // one more than the threshold on x only; low bits of y are don't-care
        send_accel(8'h2E, 8'hE0, 8'h17, 8'h6F, 8'h17, 8'h6C);
        send_host(OP_HOST, REQ_FALL);
        // unused operation and unknown host bytes give nothing
        send_host(OP_UNUSED, REQ_FALL);
        send_host(OP_HOST, 8'h00);
        send_host(OP_HOST, 8'hFF);
        send_host(OP_HOST, 8'h72);
        // two samples into a long window
        send_temp(10'h3FF);
        send_temp(10'h000);
        send_host(OP_HOST, REQ_FEVER);
        send_host(OP_HOST, REQ_TEMP);

        // Window cut below the samples already taken: the next sample closes
        // it with three samples summed, right on the fever threshold.
        settle_idle();
        set_config(14'h3FFF, 8'd2, 18'd2046);
        send_temp(10'h3FF);
        send_host(OP_HOST, REQ_TEMP);
        send_host(OP_HOST, REQ_FEVER);
        send_host(OP_HOST, REQ_FEVER);
        // one short of the threshold
        send_temp(10'h3FF);
        send_temp(10'h3FE);
        send_host(OP_HOST, REQ_FEVER);
        send_host(OP_HOST, REQ_TEMP);

        // Random phases across idling modes and register extremes; the
        // third opens with the long receiver hold-off.
        run_phase(14'd0,    8'd1,   18'd0,      0,  0, 150, 1'b0);
        run_phase(14'h3FFF, 8'd255, 18'h3FFFF, 80,  0, 150, 1'b0);
        run_phase(14'd700,  8'd3,   18'd1500,   0, 80, 200, 1'b1);
        run_phase(14'd1500, 8'd0,   18'd600,   35, 35, 150, 1'b0);
        run_phase(14'd200,  8'd5,   18'd2560,   0,  0, 200, 1'b0);
        run_phase(14'd5000, 8'd16,  18'd8192,  80,  0, 250, 1'b0);
        run_phase(14'd1,    8'd2,   18'd1024,   0, 80, 150, 1'b0);
        run_phase(14'd3000, 8'd8,   18'd4096,  35, 35, 100, 1'b0);
        settle_idle();

        if (mismatch_count == 0 && replies_pending == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
